@@ design/bbpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpe_pkg
// Field widths and codes shared by the Bezier patch evaluator and its channels.
// ----------------------------------------------------------------------------
package bbpe_pkg;

	localparam int IN_COORD_W = 32;
	localparam int PARAM_W    = 18;
	localparam int OUT_W      = 32;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_POINT  = 2'd1;
	localparam logic [1:0] CMD_FIRST  = 2'd2;
	localparam logic [1:0] CMD_SECOND = 2'd3;

	localparam logic [2:0] KIND_PT  = 3'd0;
	localparam logic [2:0] KIND_DU  = 3'd1;
	localparam logic [2:0] KIND_DV  = 3'd2;
	localparam logic [2:0] KIND_DUU = 3'd3;
	localparam logic [2:0] KIND_DUV = 3'd4;
	localparam logic [2:0] KIND_DVV = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_U_BAD = 2'd1;
	localparam logic [1:0] ST_V_BAD = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

endpackage

@@ design/bbpe_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpe_in_if / bbpe_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface bbpe_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            cmd;
	logic [3:0]                            point_index;
	logic signed [bbpe_pkg::IN_COORD_W-1:0] coord_x;
	logic signed [bbpe_pkg::IN_COORD_W-1:0] coord_y;
	logic signed [bbpe_pkg::IN_COORD_W-1:0] coord_z;
	logic signed [bbpe_pkg::PARAM_W-1:0]    u_param;
	logic signed [bbpe_pkg::PARAM_W-1:0]    v_param;

	modport source (output valid, cmd, point_index, coord_x, coord_y, coord_z,
		u_param, v_param, input ready);
	modport sink (input valid, cmd, point_index, coord_x, coord_y, coord_z,
		u_param, v_param, output ready);
endinterface

interface bbpe_out_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        result_kind;
	logic signed [bbpe_pkg::OUT_W-1:0] out_x;
	logic signed [bbpe_pkg::OUT_W-1:0] out_y;
	logic signed [bbpe_pkg::OUT_W-1:0] out_z;
	logic [1:0]                        status;
	logic                              last;

	modport source (output valid, result_kind, out_x, out_y, out_z, status, last,
		input ready);
	modport sink (input valid, result_kind, out_x, out_y, out_z, status, last,
		output ready);
endinterface

@@ design/bicubic_bezier_patch_eval_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_top
// A write is stored in the net on acceptance. Each result takes five passes (four rows along v,
// then one across u) of 4 loads plus 6 difference/lerp steps, then a registered output,
// starting after acceptance or after the previous result's handshake, all on
// one shared three-lane lerp/difference unit. Out-of-domain items give their single
// result in the cycle after acceptance. Not ready while an item is in work; ready again the
// cycle after the last result's handshake. Reset clears the net to zero.
// ----------------------------------------------------------------------------
// Evaluates a bicubic Bezier patch or its partials by de Casteljau, v then u.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_top #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bbpe_in_if.sink    in_ch,
	bbpe_out_if.source out_ch
);

	localparam int CW = COORD_WIDTH;
	localparam int XW = ((CW > bbpe_pkg::OUT_W) ? CW : bbpe_pkg::OUT_W) + 1;
	localparam int PW = CW + 1 + bbpe_pkg::PARAM_W;

	localparam logic signed [XW-1:0] CMAX_X = (XW'(1) <<< (CW - 1)) - XW'(1);
	localparam logic signed [XW-1:0] CMIN_X = -CMAX_X - XW'(1);
	localparam logic signed [XW-1:0] OMAX_X = (XW'(1) <<< (bbpe_pkg::OUT_W - 1)) - XW'(1);
	localparam logic signed [XW-1:0] OMIN_X = -OMAX_X - XW'(1);
	localparam logic signed [CW+2:0] DMAX = ((CW+3)'(1) <<< (CW - 1)) - (CW+3)'(1);
	localparam logic signed [CW+2:0] DMIN = -DMAX - (CW+3)'(1);
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [31:0]   ONE  = 32'(1) <<< FRAC_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_DIFF = 3'd2;
	localparam logic [2:0] S_LERP = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic signed [CW-1:0] net_q  [16][3];
	logic signed [CW-1:0] rows_q [4][3];
	logic signed [CW-1:0] w_q    [4][3];

	logic [2:0] state_q;
	logic [2:0] kind_q;
	logic [1:0] left_q;     // results still to compute after this one
	logic       phase_q;    // 0: along v per row, 1: along u
	logic [1:0] row_q;
	logic [1:0] i_q;
	logic [2:0] n_q;
	logic [1:0] dleft_q;
	logic [1:0] lvl_q;
	logic       ovf_q;
	logic signed [bbpe_pkg::PARAM_W-1:0] u_q;
	logic signed [bbpe_pkg::PARAM_W-1:0] v_q;

	logic       ov_q;
	logic [2:0] okind_q;
	logic [1:0] ost_q;
	logic       olast_q;
	logic signed [bbpe_pkg::OUT_W-1:0] ox_q, oy_q, oz_q;

	// order of differencing per pass
	logic [1:0] vord, uord, ord;
	always_comb begin
		vord = 2'd0;
		uord = 2'd0;
		if (kind_q == bbpe_pkg::KIND_DV || kind_q == bbpe_pkg::KIND_DUV) vord = 2'd1;
		if (kind_q == bbpe_pkg::KIND_DVV) vord = 2'd2;
		if (kind_q == bbpe_pkg::KIND_DU || kind_q == bbpe_pkg::KIND_DUV) uord = 2'd1;
		if (kind_q == bbpe_pkg::KIND_DUU) uord = 2'd2;
		ord = phase_q ? uord : vord;
	end

	// shared unit: three lanes, w[i] op w[i+1]
	logic signed [bbpe_pkg::PARAM_W-1:0] t;
	logic signed [CW-1:0] lerp_r [3];
	logic signed [CW-1:0] diff_r [3];
	logic                 diff_o [3];
	logic [1:0]           ip1;
	always_comb begin
		logic signed [CW:0]   d;
		logic signed [PW-1:0] p;
		logic signed [CW+2:0] s;
		t   = phase_q ? u_q : v_q;
		ip1 = i_q + 2'd1;
		for (int j = 0; j < 3; j++) begin
			d = $signed((CW+1)'(w_q[ip1][j])) - $signed((CW+1)'(w_q[i_q][j]));
			p = $signed(PW'(d)) * $signed(PW'(t));
			p = (p + HALF) >>> FRAC_BITS;
			lerp_r[j] = w_q[i_q][j] + p[CW-1:0];
			s = $signed((CW+3)'(d)) <<< 1;
			if (n_q == 3'd4) s = s + $signed((CW+3)'(d));
			diff_o[j] = 1'b0;
			if (s > DMAX) begin
				diff_r[j] = DMAX[CW-1:0];
				diff_o[j] = 1'b1;
			end else if (s < DMIN) begin
				diff_r[j] = DMIN[CW-1:0];
				diff_o[j] = 1'b1;
			end else begin
				diff_r[j] = s[CW-1:0];
			end
		end
	end

	// write-path saturation and output saturation
	logic signed [CW-1:0] wr_c [3];
	logic signed [bbpe_pkg::OUT_W-1:0] os_c [3];
	logic os_o [3];
	always_comb begin
		logic signed [XW-1:0] e;
		logic signed [XW-1:0] r;
		for (int j = 0; j < 3; j++) begin
			case (j)
				0:       e = $signed(XW'(in_ch.coord_x));
				1:       e = $signed(XW'(in_ch.coord_y));
				default: e = $signed(XW'(in_ch.coord_z));
			endcase
			if (e > CMAX_X) wr_c[j] = CMAX_X[CW-1:0];
			else if (e < CMIN_X) wr_c[j] = CMIN_X[CW-1:0];
			else wr_c[j] = e[CW-1:0];
			r = $signed(XW'(w_q[0][j]));
			os_o[j] = 1'b0;
			if (r > OMAX_X) begin
				os_c[j] = OMAX_X[bbpe_pkg::OUT_W-1:0];
				os_o[j] = 1'b1;
			end else if (r < OMIN_X) begin
				os_c[j] = OMIN_X[bbpe_pkg::OUT_W-1:0];
				os_o[j] = 1'b1;
			end else begin
				os_c[j] = r[bbpe_pkg::OUT_W-1:0];
			end
		end
	end

	logic signed [31:0] u_x, v_x;
	logic [2:0] first_kind;
	assign u_x = 32'(in_ch.u_param);
	assign v_x = 32'(in_ch.v_param);
	always_comb begin
		case (in_ch.cmd)
			bbpe_pkg::CMD_FIRST:  first_kind = bbpe_pkg::KIND_DU;
			bbpe_pkg::CMD_SECOND: first_kind = bbpe_pkg::KIND_DUU;
			default:              first_kind = bbpe_pkg::KIND_PT;
		endcase
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = ov_q;
	assign out_ch.result_kind = okind_q;
	assign out_ch.out_x       = ox_q;
	assign out_ch.out_y       = oy_q;
	assign out_ch.out_z       = oz_q;
	assign out_ch.status      = ost_q;
	assign out_ch.last        = olast_q;

	logic [3:0] raddr;
	assign raddr = {row_q, i_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			for (int k = 0; k < 16; k++)
				for (int j = 0; j < 3; j++) net_q[k][j] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.cmd == bbpe_pkg::CMD_WRITE) begin
							for (int j = 0; j < 3; j++) net_q[in_ch.point_index][j] <= wr_c[j];
						end else begin
							u_q     <= in_ch.u_param;
							v_q     <= in_ch.v_param;
							kind_q  <= first_kind;
							left_q  <= in_ch.cmd - 2'd1;
							phase_q <= 1'b0;
							row_q   <= 2'd0;
							i_q     <= 2'd0;
							ovf_q   <= 1'b0;
							if (u_x < 0 || u_x > ONE || v_x < 0 || v_x > ONE) begin
								ov_q    <= 1'b1;
								okind_q <= first_kind;
								ost_q   <= (u_x < 0 || u_x > ONE) ? bbpe_pkg::ST_U_BAD
									: bbpe_pkg::ST_V_BAD;
								olast_q <= 1'b1;
								ox_q    <= '0;
								oy_q    <= '0;
								oz_q    <= '0;
								left_q  <= 2'd0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_LOAD;
							end
						end
					end
				end
				S_LOAD: begin
					for (int j = 0; j < 3; j++)
						w_q[i_q][j] <= phase_q ? rows_q[i_q][j] : net_q[raddr][j];
					i_q <= i_q + 2'd1;
					if (i_q == 2'd3) begin
						n_q     <= 3'd4;
						dleft_q <= ord;
						lvl_q   <= 2'd3;
						state_q <= (ord != 2'd0) ? S_DIFF : S_LERP;
					end
				end
				S_DIFF: begin
					for (int j = 0; j < 3; j++) w_q[i_q][j] <= diff_r[j];
					if (diff_o[0] || diff_o[1] || diff_o[2]) ovf_q <= 1'b1;
					if ({1'b0, i_q} == n_q - 3'd2) begin
						i_q     <= 2'd0;
						n_q     <= n_q - 3'd1;
						dleft_q <= dleft_q - 2'd1;
						lvl_q   <= 2'(n_q - 3'd2);
						if (dleft_q == 2'd1) state_q <= S_LERP;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				S_LERP: begin
					for (int j = 0; j < 3; j++) w_q[i_q][j] <= lerp_r[j];
					if (i_q == lvl_q - 2'd1) begin
						i_q   <= 2'd0;
						lvl_q <= lvl_q - 2'd1;
						if (lvl_q == 2'd1) begin
							if (!phase_q) begin
								for (int j = 0; j < 3; j++) rows_q[row_q][j] <= lerp_r[j];
								row_q <= row_q + 2'd1;
								if (row_q == 2'd3) phase_q <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								// final value lands in w[0] this edge; emit next cycle
								state_q <= S_OUT;
								n_q     <= 3'd0;
							end
						end
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				S_OUT: begin
					if (!ov_q) begin
						ov_q    <= 1'b1;
						okind_q <= kind_q;
						ox_q    <= os_c[0];
						oy_q    <= os_c[1];
						oz_q    <= os_c[2];
						ost_q   <= (ovf_q || os_o[0] || os_o[1] || os_o[2])
							? bbpe_pkg::ST_OVF : bbpe_pkg::ST_OK;
						olast_q <= (left_q == 2'd0);
					end else if (out_ch.ready) begin
						ov_q <= 1'b0;
						if (left_q == 2'd0) begin
							state_q <= S_IDLE;
						end else begin
							left_q  <= left_q - 2'd1;
							kind_q  <= kind_q + 3'd1;
							phase_q <= 1'b0;
							row_q   <= 2'd0;
							i_q     <= 2'd0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
